FILE: rtl/greek_to_latin_transliterator_assert.svh
`ifndef GREEK_TO_LATIN_TRANSLITERATOR_ASSERT_SVH
`define GREEK_TO_LATIN_TRANSLITERATOR_ASSERT_SVH

// Same-cycle implication, switched off while reset is high.
`define GRL_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("grl assertion failed");

// Next-cycle implication, switched off while reset is high.
`define GRL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("grl assertion failed");

// Next-cycle implication that is checked through reset as well.
`define GRL_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("grl assertion failed");

`endif

FILE: rtl/grl_pkg.sv
package grl_pkg;

  // Greek codes that take part in the mu and nu pairing rules.
  localparam logic [7:0] GR_UPPER_MU  = 8'd204;
  localparam logic [7:0] GR_LOWER_MU  = 8'd236;
  localparam logic [7:0] GR_UPPER_NU  = 8'd205;
  localparam logic [7:0] GR_LOWER_NU  = 8'd237;
  localparam logic [7:0] GR_UPPER_PI  = 8'd208;
  localparam logic [7:0] GR_LOWER_PI  = 8'd240;
  localparam logic [7:0] GR_UPPER_TAU = 8'd212;
  localparam logic [7:0] GR_LOWER_TAU = 8'd244;

  // Latin letters for a flushed or a paired held letter.
  localparam logic [7:0] LAT_UPPER_M = 8'd77;
  localparam logic [7:0] LAT_LOWER_M = 8'd109;
  localparam logic [7:0] LAT_UPPER_N = 8'd78;
  localparam logic [7:0] LAT_LOWER_N = 8'd110;
  localparam logic [7:0] LAT_UPPER_B = 8'd66;
  localparam logic [7:0] LAT_LOWER_B = 8'd98;
  localparam logic [7:0] LAT_UPPER_D = 8'd68;
  localparam logic [7:0] LAT_LOWER_D = 8'd100;

  localparam int JOB_BYTES  = 4;
  localparam int JOB_IDX_W  = $clog2(JOB_BYTES);
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [2:0] {
    PEND_NONE = 3'd0,
    PEND_UMU  = 3'd1,
    PEND_LMU  = 3'd2,
    PEND_UNU  = 3'd3,
    PEND_LNU  = 3'd4
  } pend_t;

  // One burst of output bytes for the back end; last_idx is the index of the
  // final byte, so an empty burst cannot be expressed.
  typedef struct packed {
    logic [JOB_BYTES-1:0][7:0] bytes;
    logic [JOB_IDX_W-1:0]      last_idx;
  } grl_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } grl_fifo_stat_t;

  function automatic logic [23:0] rom_pack(input logic [7:0] b0, input logic [7:0] b1,
                                           input logic [7:0] b2);
    return {b2, b1, b0};
  endfunction

  // Transliteration table: first byte in the low bits, zero bytes unused.
  function automatic logic [23:0] rom_entry(input logic [7:0] c);
    logic [23:0] e;
    case (c)
      8'd168: e = rom_pack(8'd34, 8'd0, 8'd0);
      8'd180: e = rom_pack(8'd39, 8'd0, 8'd0);
      8'd181: e = rom_pack(8'd39, 8'd34, 8'd0);
      8'd182: e = rom_pack(8'd39, 8'd65, 8'd0);
      8'd184: e = rom_pack(8'd39, 8'd69, 8'd0);
      8'd185: e = rom_pack(8'd39, 8'd72, 8'd0);
      8'd186: e = rom_pack(8'd39, 8'd73, 8'd0);
      8'd188: e = rom_pack(8'd39, 8'd79, 8'd0);
      8'd190: e = rom_pack(8'd39, 8'd89, 8'd0);
      8'd191: e = rom_pack(8'd39, 8'd87, 8'd0);
      8'd192: e = rom_pack(8'd105, 8'd34, 8'd39);
      8'd193: e = rom_pack(8'd65, 8'd0, 8'd0);
      8'd194: e = rom_pack(8'd86, 8'd0, 8'd0);
      8'd195: e = rom_pack(8'd71, 8'd0, 8'd0);
      8'd196: e = rom_pack(8'd68, 8'd0, 8'd0);
      8'd197: e = rom_pack(8'd69, 8'd0, 8'd0);
      8'd198: e = rom_pack(8'd90, 8'd0, 8'd0);
      8'd199: e = rom_pack(8'd72, 8'd0, 8'd0);
      8'd200: e = rom_pack(8'd56, 8'd0, 8'd0);
      8'd201: e = rom_pack(8'd73, 8'd0, 8'd0);
      8'd202: e = rom_pack(8'd75, 8'd0, 8'd0);
      8'd203: e = rom_pack(8'd76, 8'd0, 8'd0);
      8'd204: e = rom_pack(8'd77, 8'd0, 8'd0);
      8'd205: e = rom_pack(8'd78, 8'd0, 8'd0);
      8'd206: e = rom_pack(8'd75, 8'd83, 8'd0);
      8'd207: e = rom_pack(8'd79, 8'd0, 8'd0);
      8'd208: e = rom_pack(8'd80, 8'd0, 8'd0);
      8'd209: e = rom_pack(8'd82, 8'd0, 8'd0);
      8'd211: e = rom_pack(8'd83, 8'd0, 8'd0);
      8'd212: e = rom_pack(8'd84, 8'd0, 8'd0);
      8'd213: e = rom_pack(8'd89, 8'd0, 8'd0);
      8'd214: e = rom_pack(8'd70, 8'd0, 8'd0);
      8'd215: e = rom_pack(8'd88, 8'd0, 8'd0);
      8'd216: e = rom_pack(8'd80, 8'd83, 8'd0);
      8'd217: e = rom_pack(8'd87, 8'd0, 8'd0);
      8'd218: e = rom_pack(8'd34, 8'd73, 8'd0);
      8'd219: e = rom_pack(8'd34, 8'd89, 8'd0);
      8'd220: e = rom_pack(8'd97, 8'd39, 8'd0);
      8'd221: e = rom_pack(8'd101, 8'd39, 8'd0);
      8'd222: e = rom_pack(8'd104, 8'd39, 8'd0);
      8'd223: e = rom_pack(8'd105, 8'd39, 8'd0);
      8'd224: e = rom_pack(8'd121, 8'd34, 8'd39);
      8'd225: e = rom_pack(8'd97, 8'd0, 8'd0);
      8'd226: e = rom_pack(8'd118, 8'd0, 8'd0);
      8'd227: e = rom_pack(8'd103, 8'd0, 8'd0);
      8'd228: e = rom_pack(8'd100, 8'd0, 8'd0);
      8'd229: e = rom_pack(8'd101, 8'd0, 8'd0);
      8'd230: e = rom_pack(8'd122, 8'd0, 8'd0);
      8'd231: e = rom_pack(8'd104, 8'd0, 8'd0);
      8'd232: e = rom_pack(8'd56, 8'd0, 8'd0);
      8'd233: e = rom_pack(8'd105, 8'd0, 8'd0);
      8'd234: e = rom_pack(8'd107, 8'd0, 8'd0);
      8'd235: e = rom_pack(8'd108, 8'd0, 8'd0);
      8'd236: e = rom_pack(8'd109, 8'd0, 8'd0);
      8'd237: e = rom_pack(8'd110, 8'd0, 8'd0);
      8'd238: e = rom_pack(8'd107, 8'd115, 8'd0);
      8'd239: e = rom_pack(8'd111, 8'd0, 8'd0);
      8'd240: e = rom_pack(8'd112, 8'd0, 8'd0);
      8'd241: e = rom_pack(8'd114, 8'd0, 8'd0);
      8'd242: e = rom_pack(8'd115, 8'd0, 8'd0);
      8'd243: e = rom_pack(8'd115, 8'd0, 8'd0);
      8'd244: e = rom_pack(8'd116, 8'd0, 8'd0);
      8'd245: e = rom_pack(8'd121, 8'd0, 8'd0);
      8'd246: e = rom_pack(8'd102, 8'd0, 8'd0);
      8'd247: e = rom_pack(8'd120, 8'd0, 8'd0);
      8'd248: e = rom_pack(8'd112, 8'd115, 8'd0);
      8'd249: e = rom_pack(8'd119, 8'd0, 8'd0);
      8'd250: e = rom_pack(8'd105, 8'd34, 8'd0);
      8'd251: e = rom_pack(8'd121, 8'd34, 8'd0);
      8'd252: e = rom_pack(8'd111, 8'd39, 8'd0);
      8'd253: e = rom_pack(8'd121, 8'd39, 8'd0);
      8'd254: e = rom_pack(8'd119, 8'd39, 8'd0);
      default: e = 24'd0;
    endcase
    return e;
  endfunction

  // Number of used bytes in a table entry (entries are filled from the bottom).
  function automatic logic [1:0] rom_len(input logic [23:0] e);
    logic [1:0] n;
    if (e[7:0] == 8'd0) begin
      n = 2'd0;
    end else if (e[15:8] == 8'd0) begin
      n = 2'd1;
    end else if (e[23:16] == 8'd0) begin
      n = 2'd2;
    end else begin
      n = 2'd3;
    end
    return n;
  endfunction

  function automatic pend_t hold_code(input logic [7:0] c);
    pend_t h;
    case (c)
      GR_UPPER_MU: h = PEND_UMU;
      GR_LOWER_MU: h = PEND_LMU;
      GR_UPPER_NU: h = PEND_UNU;
      GR_LOWER_NU: h = PEND_LNU;
      default:     h = PEND_NONE;
    endcase
    return h;
  endfunction

  function automatic logic [7:0] flush_char(input pend_t p);
    logic [7:0] b;
    case (p)
      PEND_UMU: b = LAT_UPPER_M;
      PEND_LMU: b = LAT_LOWER_M;
      PEND_UNU: b = LAT_UPPER_N;
      PEND_LNU: b = LAT_LOWER_N;
      default:  b = 8'd0;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] pair_char(input pend_t p);
    logic [7:0] b;
    case (p)
      PEND_UMU: b = LAT_UPPER_B;
      PEND_LMU: b = LAT_LOWER_B;
      PEND_UNU: b = LAT_UPPER_D;
      PEND_LNU: b = LAT_LOWER_D;
      default:  b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

FILE: rtl/greek_to_latin_transliterator.sv
// Each job is written to the job queue, then popped into the output register for sending.
// The front end takes one request per cycle while the queue is not full; a request that
// causes n bytes, four at worst, holds the one-byte output channel for n transfers.
// Reset: synchronous, active high; clears the held letter, the job queue and the output
// valid. The transliteration table is constant logic and is not affected.
//
// The block is split into a front end and a back end joined by a four-entry job queue.
// The front end takes one ISO-8859-7 code per request, looks it up in the transliteration
// table and applies the mu and nu pairing rules against the held letter. Each request
// that yields output becomes one job of one to four Latin bytes; a request that only
// makes mu or nu pending produces no job at all. The front end stalls only when the
// queue is full.
//
// The back end pops one job at a time into its output register and presents the bytes
// in order, raising tlast on the final byte of each job. If the queue holds the next job,
// it pops it in the same cycle that the last byte of the current one is taken, so
// consecutive jobs leave with no idle cycle between them.
//
// A letter still held when the input stream stops is not flushed.
module greek_to_latin_transliterator
  import grl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast
);

  grl_fifo_stat_t fifo_stat;
  grl_job_t       push_job;
  grl_job_t       head_job;
  logic           push;
  logic           pop;

  // Classification and held-letter handling.
  grl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_byte   (s_axis_tdata),
    .fifo_stat (fifo_stat),
    .push      (push),
    .push_job  (push_job)
  );

  // Jobs waiting for the output side.
  grl_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .stat     (fifo_stat)
  );

  // Byte-by-byte delivery of each job.
  grl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_job  (head_job),
    .fifo_stat (fifo_stat),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_byte  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

FILE: rtl/grl_fifo.sv
module grl_fifo
  import grl_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  grl_job_t       push_job,
  input  logic           pop,
  output grl_job_t       head_job,
  output grl_fifo_stat_t stat
);

  grl_job_t                mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr;
  logic [FIFO_PTR_W-1:0]   rd_ptr;
  logic [FIFO_CNT_W-1:0]   count;
  logic                    do_push;
  logic                    do_pop;

  assign stat.full  = (count == FIFO_CNT_W'(FIFO_DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_job   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/grl_front.sv
module grl_front
  import grl_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     in_byte,
  input  grl_fifo_stat_t fifo_stat,
  output logic           push,
  output grl_job_t       push_job
);

  pend_t             pend;
  pend_t             pend_next;
  pend_t             hold;
  logic [23:0]       rom_e;
  logic [1:0]        rom_n;
  logic [2:0][7:0]   rom_b;
  logic [1:0]        rom_last;
  logic              is_mu;
  logic              pairs;
  logic              emit;
  logic              accept;

  assign in_ready = !fifo_stat.full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && emit;

  always_comb begin
    hold  = hold_code(in_byte);
    rom_e = rom_entry(in_byte);
    rom_n = rom_len(rom_e);
    // An empty table entry passes the code through as a single byte.
    if (rom_n == 2'd0) begin
      rom_b    = {16'd0, in_byte};
      rom_last = 2'd0;
    end else begin
      rom_b    = rom_e;
      rom_last = rom_n - 2'd1;
    end

    is_mu = (pend == PEND_UMU) || (pend == PEND_LMU);
    pairs = is_mu ? ((in_byte == GR_UPPER_PI) || (in_byte == GR_LOWER_PI))
                  : ((in_byte == GR_UPPER_TAU) || (in_byte == GR_LOWER_TAU));

    pend_next         = pend;
    emit              = 1'b0;
    push_job.bytes    = '0;
    push_job.last_idx = '0;

    if (pend == PEND_NONE) begin
      if (hold != PEND_NONE) begin
        pend_next = hold;
      end else begin
        emit              = 1'b1;
        push_job.bytes    = {8'd0, rom_b};
        push_job.last_idx = JOB_IDX_W'(rom_last);
      end
    end else if (pairs) begin
      emit              = 1'b1;
      push_job.bytes    = {24'd0, pair_char(pend)};
      push_job.last_idx = '0;
      pend_next         = PEND_NONE;
    end else if (hold != PEND_NONE) begin
      emit              = 1'b1;
      push_job.bytes    = {24'd0, flush_char(pend)};
      push_job.last_idx = '0;
      pend_next         = hold;
    end else begin
      emit              = 1'b1;
      push_job.bytes    = {rom_b, flush_char(pend)};
      push_job.last_idx = JOB_IDX_W'(rom_last) + 1'b1;
      pend_next         = PEND_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= PEND_NONE;
    end else if (accept) begin
      pend <= pend_next;
    end
  end

endmodule

FILE: rtl/grl_back.sv
module grl_back
  import grl_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  grl_job_t       head_job,
  input  grl_fifo_stat_t fifo_stat,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic           out_last
);

  grl_job_t              job;
  logic                  valid;
  logic [JOB_IDX_W-1:0]  idx;
  logic                  taken;

  assign out_valid = valid;
  assign out_byte  = job.bytes[idx];
  assign out_last  = (idx == job.last_idx);
  assign taken     = valid && out_ready;
  assign pop       = !fifo_stat.empty && (!valid || (taken && out_last));

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= head_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= '0;
    end else if (pop) begin
      valid <= 1'b1;
      idx   <= '0;
    end else if (taken) begin
      if (out_last) begin
        valid <= 1'b0;
        idx   <= '0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

endmodule

FILE: rtl/grl_checker.sv
`include "greek_to_latin_transliterator_assert.svh"

module grl_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  logic in_taken;
  logic out_stall;
  logic quiet;
  assign in_taken  = s_axis_tvalid && s_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign quiet     = !m_axis_tvalid && !in_taken && s_axis_tready;

  // A stalled output byte stays offered.
  `GRL_ASSERT_NEXT(a_out_hold_valid, clk, rst, out_stall, m_axis_tvalid)

  // A stalled output byte keeps its value and its last flag.
  `GRL_ASSERT_NEXT(a_out_hold_data, clk, rst, out_stall, $stable(m_axis_tdata) && $stable(m_axis_tlast))

  // Reset leaves nothing to deliver and an empty queue ready for requests.
  `GRL_ASSERT_ALWAYS_NEXT(a_reset_idle, clk, rst, !m_axis_tvalid && s_axis_tready)

  // An empty output side with no request taken, also as sampled by $past, cannot start a byte in the next cycle.
  `GRL_ASSERT_NEXT(a_no_spurious_out, clk, rst, quiet && $past(quiet), !m_axis_tvalid)

endmodule

bind greek_to_latin_transliterator grl_checker u_grl_checker (.*);
